// ===== design/fnv1a_hash_with_final_mix_core_assert.svh =====
// Assertion macros shared by the hash core.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef FNV1A_HASH_WITH_FINAL_MIX_CORE_ASSERT_SVH
`define FNV1A_HASH_WITH_FINAL_MIX_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FNVMIX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fnvmix same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FNVMIX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fnvmix next-cycle check failed");

`endif

// ===== design/fnvmix_pkg.sv =====
`default_nettype none

package fnvmix_pkg;

  localparam int unsigned HASH_W = 32;
  localparam int unsigned BYTE_W = 8;

  localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

  // Shift amounts of the finishing mix.
  localparam int unsigned MIX_SH_A = 13;
  localparam int unsigned MIX_SH_B = 7;
  localparam int unsigned MIX_SH_C = 3;
  localparam int unsigned MIX_SH_D = 17;
  localparam int unsigned MIX_SH_E = 5;

  // Product of a byte step, valid only when the byte closed a message.
  typedef struct packed {
    logic              vld;
    logic [HASH_W-1:0] hash;
  } prod_t;

  // First mix step: add the left shift, then fold in the right shift.
  function automatic logic [HASH_W-1:0] mix_first(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] t;
    t = h + (h << MIX_SH_A);
    return t ^ (t >> MIX_SH_B);
  endfunction

  // Second mix step.
  function automatic logic [HASH_W-1:0] mix_second(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] t;
    t = h + (h << MIX_SH_C);
    return t ^ (t >> MIX_SH_D);
  endfunction

  // Last mix step.
  function automatic logic [HASH_W-1:0] mix_last(input logic [HASH_W-1:0] h);
    return h + (h << MIX_SH_E);
  endfunction

endpackage

`default_nettype wire

// ===== design/fnvmix_msg_if.sv =====
`default_nettype none

// Message byte channel.
interface fnvmix_msg_if;
  logic                          valid;
  logic                          ready;
  logic [fnvmix_pkg::BYTE_W-1:0] msg_byte;
  logic                          is_last;

  modport source (output valid, output msg_byte, output is_last, input ready);
  modport sink (input valid, input msg_byte, input is_last, output ready);
endinterface

`default_nettype wire

// ===== design/fnvmix_hash_if.sv =====
`default_nettype none

// Finished hash channel.
interface fnvmix_hash_if;
  logic                          valid;
  logic                          ready;
  logic [fnvmix_pkg::HASH_W-1:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

// ===== design/fnvmix_accum.sv =====
`default_nettype none

// Running FNV-1a state: seed register, message flag and per-byte update.
module fnvmix_accum (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [fnvmix_pkg::HASH_W-1:0] cfg_wdata_i,
  input  wire logic                          acc_en_i,
  input  wire logic [fnvmix_pkg::BYTE_W-1:0] msg_byte_i,
  input  wire logic                          is_last_i,
  output fnvmix_pkg::prod_t                  prod_o,
  output logic                               in_msg_o
);

  logic [fnvmix_pkg::HASH_W-1:0] seed_q, seed_d;
  logic [fnvmix_pkg::HASH_W-1:0] run_q, run_d;
  logic                          in_msg_q, in_msg_d;
  logic [fnvmix_pkg::HASH_W-1:0] h_start;
  logic [fnvmix_pkg::HASH_W-1:0] h_mixed;
  logic [fnvmix_pkg::HASH_W-1:0] h_prod;

  // A new message starts from the basis XOR the seed, otherwise from the running hash.
  always_comb begin
    h_start = in_msg_q ? run_q : (fnvmix_pkg::FNV_BASIS ^ seed_q);
    h_mixed = h_start ^ {{(fnvmix_pkg::HASH_W - fnvmix_pkg::BYTE_W){1'b0}}, msg_byte_i};
    h_prod  = h_mixed * fnvmix_pkg::FNV_PRIME;
  end

  // Next state for the seed, the running hash and the message flag.
  always_comb begin
    seed_d   = cfg_we_i ? cfg_wdata_i : seed_q;
    run_d    = run_q;
    in_msg_d = in_msg_q;
    if (acc_en_i) begin
      run_d    = h_prod;
      in_msg_d = !is_last_i;
    end
  end

  // Control state and the seed reset; the running hash is only read mid-message.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= '0;
      in_msg_q <= 1'b0;
    end else begin
      seed_q   <= seed_d;
      in_msg_q <= in_msg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q <= run_d;
  end

  // A closing byte hands its product to the finishing pipeline.
  assign prod_o.vld  = acc_en_i && is_last_i;
  assign prod_o.hash = h_prod;
  assign in_msg_o    = in_msg_q;

endmodule

`default_nettype wire

// ===== design/fnvmix_finish.sv =====
`default_nettype none

// Finishing mix pipeline: product register, two mix stages, result register.
module fnvmix_finish (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fnvmix_pkg::prod_t             prod_i,
  output logic                               ready_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [fnvmix_pkg::HASH_W-1:0]      hash_value_o
);

  logic                          v_p_q, v_p_d;
  logic                          v_a_q, v_a_d;
  logic                          v_b_q, v_b_d;
  logic                          v_o_q, v_o_d;
  logic [fnvmix_pkg::HASH_W-1:0] h_p_q, h_a_q, h_b_q, h_o_q;
  logic                          en_p, en_a, en_b, en_o;

  // A stage loads when it is empty or its content moves on this cycle.
  always_comb begin
    en_o = !v_o_q || out_ready_i;
    en_b = !v_b_q || en_o;
    en_a = !v_a_q || en_b;
    en_p = !v_p_q || en_a;
  end

  // Valid bits advance with their stage enables.
  always_comb begin
    v_p_d = en_p ? prod_i.vld : v_p_q;
    v_a_d = en_a ? v_p_q : v_a_q;
    v_b_d = en_b ? v_a_q : v_b_q;
    v_o_d = en_o ? v_b_q : v_o_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_p_q <= 1'b0;
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_o_q <= 1'b0;
    end else begin
      v_p_q <= v_p_d;
      v_a_q <= v_a_d;
      v_b_q <= v_b_d;
      v_o_q <= v_o_d;
    end
  end

  // Data registers: the product register takes the closing product, and each later stage applies one mix step.
  always_ff @(posedge clk_i) begin
    if (en_p && prod_i.vld) begin
      h_p_q <= prod_i.hash;
    end
    if (en_a && v_p_q) begin
      h_a_q <= fnvmix_pkg::mix_first(h_p_q);
    end
    if (en_b && v_a_q) begin
      h_b_q <= fnvmix_pkg::mix_second(h_a_q);
    end
    if (en_o && v_b_q) begin
      h_o_q <= fnvmix_pkg::mix_last(h_b_q);
    end
  end

  assign ready_o      = en_p;
  assign out_valid_o  = v_o_q;
  assign hash_value_o = h_o_q;

endmodule

`default_nettype wire

// ===== design/fnv1a_hash_with_final_mix_core.sv =====
// Seeded FNV-1a hash core with a shift-add/xor finishing mix.
// Channels: msg_i carries one unsigned message byte per request, with is_last
// marking the final byte of a message; hash_o carries one finished 32-bit
// hash per message. cfg_we_i/cfg_wdata_i write the 32-bit seed, which is
// XORed into the FNV offset basis when the next message starts; a write in
// the middle of a message leaves that message alone.
// Throughput: one byte per cycle while msg_i.ready is high. The running hash update
// (XOR and constant multiply by the FNV prime) is combinational, which sets that rate.
// The hash of a message reaches hash_o from its last accepted byte through a
// product register, two mix stages and the result register.
// Stalls: each pipeline stage holds its request while hash_o is not taken;
// msg_i.ready drops only when all four stages are full and hash_o is stalled.
// Reset: the seed clears to zero, no message is in progress and the
// pipeline is empty.
`default_nettype none

`include "fnv1a_hash_with_final_mix_core_assert.svh"

module fnv1a_hash_with_final_mix_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [fnvmix_pkg::HASH_W-1:0] cfg_wdata_i,
  fnvmix_msg_if.sink                         msg_i,
  fnvmix_hash_if.source                      hash_o
);

  fnvmix_pkg::prod_t prod;
  logic              acc_en;
  logic              in_msg;
  logic              fin_ready;

  // A byte request is accepted when valid meets ready.
  assign acc_en      = msg_i.valid && fin_ready;
  assign msg_i.ready = fin_ready;

  fnvmix_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_en_i    (acc_en),
    .msg_byte_i  (msg_i.msg_byte),
    .is_last_i   (msg_i.is_last),
    .prod_o      (prod),
    .in_msg_o    (in_msg)
  );

  fnvmix_finish u_finish (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prod_i       (prod),
    .ready_o      (fin_ready),
    .out_valid_o  (hash_o.valid),
    .out_ready_i  (hash_o.ready),
    .hash_value_o (hash_o.hash_value)
  );

  // The input only backs up when the result is held by a stalled receiver.
  `FNVMIX_ASSERT_NOW(a_stall_cause, !msg_i.ready, hash_o.valid && !hash_o.ready)
  // A last byte closes the message.
  `FNVMIX_ASSERT_NEXT(a_msg_close, msg_i.valid && msg_i.ready && msg_i.is_last, !in_msg)
  // Any other byte leaves a message open.
  `FNVMIX_ASSERT_NEXT(a_msg_open, msg_i.valid && msg_i.ready && !msg_i.is_last, in_msg)

endmodule

`default_nettype wire

// ===== tb/sv/fnv1a_hash_with_final_mix_core_tb.sv =====
`default_nettype none

module fnv1a_hash_with_final_mix_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Tracks the seeded running hash and the finished hashes still owed by the core.
  class hash_scoreboard;
    logic [fnvmix_pkg::HASH_W-1:0] seed;
    logic [fnvmix_pkg::HASH_W-1:0] chain_hash;
    bit                            mid_message;
    logic [fnvmix_pkg::HASH_W-1:0] owed_hashes[$];
    int unsigned                   failures;
    int unsigned                   hashes_checked;

    function new();
      seed           = '0;
      chain_hash     = fnvmix_pkg::FNV_BASIS;
      mid_message    = 1'b0;
      failures       = 0;
      hashes_checked = 0;
    endfunction

    // A new seed reaches the running hash only between messages.
    function void load_seed(logic [fnvmix_pkg::HASH_W-1:0] s);
      seed = s;
      if (!mid_message) begin
        chain_hash = fnvmix_pkg::FNV_BASIS ^ s;
      end
    endfunction

    // Shift-add/xor avalanche applied once a message closes.
    function logic [fnvmix_pkg::HASH_W-1:0] fold_mix(logic [fnvmix_pkg::HASH_W-1:0] h);
      logic [fnvmix_pkg::HASH_W-1:0] m;
      m = h;
      m = m + (m << fnvmix_pkg::MIX_SH_A);
      m = m ^ (m >> fnvmix_pkg::MIX_SH_B);
      m = m + (m << fnvmix_pkg::MIX_SH_C);
      m = m ^ (m >> fnvmix_pkg::MIX_SH_D);
      m = m + (m << fnvmix_pkg::MIX_SH_E);
      return m;
    endfunction

    // Folds one accepted byte into the running hash.
    function void note_byte(logic [fnvmix_pkg::BYTE_W-1:0] b, bit last);
      logic [fnvmix_pkg::HASH_W-1:0] h;
      h = mid_message ? chain_hash : (fnvmix_pkg::FNV_BASIS ^ seed);
      h = (h ^ {{(fnvmix_pkg::HASH_W - fnvmix_pkg::BYTE_W){1'b0}}, b})
          * fnvmix_pkg::FNV_PRIME;
      if (last) begin
        owed_hashes.push_back(fold_mix(h));
        chain_hash  = fnvmix_pkg::FNV_BASIS ^ seed;
        mid_message = 1'b0;
      end else begin
        chain_hash  = h;
        mid_message = 1'b1;
      end
    endfunction

    // Compares one delivered hash with the oldest owed one.
    function void check_hash(logic [fnvmix_pkg::HASH_W-1:0] got);
      logic [fnvmix_pkg::HASH_W-1:0] want;
      hashes_checked++;
      if (owed_hashes.size() == 0) begin
        $display("%0t: hash_value expected none, actual %08h", $time, got);
        failures++;
      end else begin
        want = owed_hashes.pop_front();
        if (got !== want) begin
          $display("%0t: hash_value expected %08h, actual %08h", $time, want, got);
          failures++;
        end
      end
    endfunction

    // Any hash still owed at the end never arrived.
    function void flush_owed();
      while (owed_hashes.size() != 0) begin
        $display("%0t: hash_value expected %08h, actual none", $time, owed_hashes.pop_front());
        failures++;
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we;
  logic [fnvmix_pkg::HASH_W-1:0] cfg_wdata;

  fnvmix_msg_if  msg_ch ();
  fnvmix_hash_if hash_ch ();

  fnv1a_hash_with_final_mix_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .msg_i      (msg_ch),
    .hash_o     (hash_ch)
  );

  hash_scoreboard sb;
  bit             send_gaps;
  bit             recv_stalls;
  bit             long_hold_req;
  int unsigned    bytes_sent;
  int unsigned    msgs_sent;
  int unsigned    seeds_written;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the core hangs.
  initial begin
    #3_000_000;
    $display("fnv1a_hash_with_final_mix_core: mismatch");
    $finish;
  end

  // Random message byte.
  function automatic logic [fnvmix_pkg::BYTE_W-1:0] rand_byte();
    int unsigned r;
    r = $urandom_range(0, 255);
    return r[fnvmix_pkg::BYTE_W-1:0];
  endfunction

  // Offers one byte request and waits until the core takes it.
  task automatic send_byte(input logic [fnvmix_pkg::BYTE_W-1:0] b, input bit last);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      msg_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    msg_ch.valid    <= 1'b1;
    msg_ch.msg_byte <= b;
    msg_ch.is_last  <= last;
    @(posedge clk_i);
    while (!msg_ch.ready) @(posedge clk_i);
    sb.note_byte(b, last);
    bytes_sent++;
    if (last) begin
      msgs_sent++;
    end
  endtask

  // Sends random bytes; the last one closes the message when asked to.
  task automatic send_message(input int unsigned len, input bit closed);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(rand_byte(), closed && (i == len - 1));
    end
  endtask

  // Drops the byte request and lets the pipeline drain before a seed change.
  task automatic settle();
    int unsigned guard;
    guard = 0;
    msg_ch.valid <= 1'b0;
    while (sb.owed_hashes.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [fnvmix_pkg::HASH_W-1:0] s);
    cfg_we    <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk_i);
    sb.load_seed(s);
    seeds_written++;
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hash receiver with random stall bursts and an occasional long hold-off.
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left    = 0;
    hold_left     = 0;
    hash_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hash_ch.valid && hash_ch.ready) begin
        sb.check_hash(hash_ch.hash_value);
      end
      if (long_hold_req) begin
        hold_left     = 60;
        long_hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        hash_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        hash_ch.ready <= 1'b0;
      end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
        stall_left    = $urandom_range(1, 11) - 1;
        hash_ch.ready <= 1'b0;
      end else begin
        hash_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned target;
    sb              = new();
    send_gaps       = 1'b1;
    recv_stalls     = 1'b1;
    long_hold_req   = 1'b0;
    bytes_sent      = 0;
    msgs_sent       = 0;
    seeds_written   = 0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    msg_ch.valid    = 1'b0;
    msg_ch.msg_byte = '0;
    msg_ch.is_last  = 1'b0;
    rst_ni          = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single-byte messages at both byte extremes, then a four-byte message, with the reset seed.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);

    // A seed change inside a message must leave that message on the old seed.
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    settle();
    write_seed(32'hFFFF_FFFF);
    send_byte(8'h56, 1'b1);
    send_byte(8'h80, 1'b1);

    // A seed change between messages takes effect at once.
    settle();
    write_seed(32'h0000_0000);
    send_byte(8'h01, 1'b1);
    send_message(12, 1'b1);

    // Random phases, each under its own seed, with idling turned on or off.
    for (int p = 0; p < 5; p++) begin
      settle();
      case (p)
        0: write_seed(32'h8000_0000);
        1: write_seed($urandom());
        2: write_seed(32'hFFFF_FFFF);
        3: write_seed(32'h0000_0001);
        default: write_seed($urandom());
      endcase
      send_gaps   = (p != 2) && (p != 4);
      recv_stalls = (p != 2) && (p != 4);

      // Back-to-back short messages against a held-off receiver fill the pipeline.
      if (p == 1) begin
        send_gaps     = 1'b0;
        long_hold_req = 1'b1;
        repeat (24) send_byte(rand_byte(), 1'b1);
        send_gaps = 1'b1;
      end

      target = bytes_sent + 100;
      while (bytes_sent < target) begin
        send_message(($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                 : $urandom_range(1, 8), 1'b1);
      end

      // Leave a message open so the next seed write lands inside it.
      if (p == 3) begin
        send_message($urandom_range(1, 5), 1'b0);
      end
    end

    settle();
    sb.flush_owed();
    $display("Hashed %0d bytes in %0d messages over %0d seed writes; %0d hashes compared.",
             bytes_sent, msgs_sent, seeds_written, sb.hashes_checked);
    $display("Seed changes both inside and between messages, a long output hold-off "
             , "and random stalls on both channels were exercised.");
    if (sb.failures == 0) begin
      $display("fnv1a_hash_with_final_mix_core: match");
    end else begin
      $display("fnv1a_hash_with_final_mix_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
